>>> src/des_block_encrypt_unit_defines.svh
// Assertion helpers for the DES encrypt unit.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef DES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define DES_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DESBE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("desbe check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define DESBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("desbe check failed in the next cycle");

`endif

>>> src/desbe_pkg.sv
`default_nettype none

package desbe_pkg;

    localparam int BLOCK_W  = 64;
    localparam int HALF_W   = 32;
    localparam int KEY_W    = 64;
    localparam int CD_W     = 56;
    localparam int HALF_CD  = 28;
    localparam int SUBKEY_W = 48;
    localparam int ROUNDS   = 16;

    typedef logic [BLOCK_W-1:0]  block_t;
    typedef logic [HALF_W-1:0]   half_t;
    typedef logic [SUBKEY_W-1:0] subkey_t;

    // Bit positions use DES numbering: position 1 is the most significant bit.
    localparam logic [6:0] IP_TAB [64] = '{
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
    };

    localparam logic [6:0] FP_TAB [64] = '{
        7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
        7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
        7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
        7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
        7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
        7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
        7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
        7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
    };

    localparam logic [5:0] E_TAB [48] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    localparam logic [5:0] P_TAB [32] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
        7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
        7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
        7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
        7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
        7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
        7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    localparam int ROT_TAB [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

    localparam logic [3:0] SBOX [8][64] = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
          4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
          4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
          4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
          4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
          4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
          4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
          4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
          4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
          4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
          4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
          4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
          4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
          4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
          4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
          4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
          4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
          4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
          4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
          4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
          4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
          4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
          4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
          4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
          4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
          4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
          4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
          4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
          4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
          4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
          4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
          4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
          4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
          4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
          4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
          4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
          4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
          4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
          4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
          4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
          4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
          4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
          4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
          4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
          4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
          4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
          4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
          4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
          4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
    };

    function automatic block_t perm_ip(input block_t v);
        block_t     r;
        logic [5:0] idx;
        for (int i = 0; i < 64; i++)
        begin
            idx = 6'(7'd64 - IP_TAB[i]);
            r[63-i] = v[idx];
        end
        return r;
    endfunction

    function automatic block_t perm_fp(input block_t v);
        block_t     r;
        logic [5:0] idx;
        for (int i = 0; i < 64; i++)
        begin
            idx = 6'(7'd64 - FP_TAB[i]);
            r[63-i] = v[idx];
        end
        return r;
    endfunction

    function automatic subkey_t expand_e(input half_t v);
        subkey_t    r;
        logic [4:0] idx;
        for (int i = 0; i < 48; i++)
        begin
            idx = 5'(6'd32 - E_TAB[i]);
            r[47-i] = v[idx];
        end
        return r;
    endfunction

    function automatic half_t perm_p(input half_t v);
        half_t      r;
        logic [4:0] idx;
        for (int i = 0; i < 32; i++)
        begin
            idx = 5'(6'd32 - P_TAB[i]);
            r[31-i] = v[idx];
        end
        return r;
    endfunction

    function automatic logic [CD_W-1:0] perm_pc1(input logic [KEY_W-1:0] v);
        logic [CD_W-1:0] r;
        logic [5:0]      idx;
        for (int i = 0; i < 56; i++)
        begin
            idx = 6'(7'd64 - PC1_TAB[i]);
            r[55-i] = v[idx];
        end
        return r;
    endfunction

    function automatic subkey_t perm_pc2(input logic [CD_W-1:0] v);
        subkey_t    r;
        logic [5:0] idx;
        for (int i = 0; i < 48; i++)
        begin
            idx = 6'(6'd56 - PC2_TAB[i]);
            r[47-i] = v[idx];
        end
        return r;
    endfunction

    // Eight S-boxes: outer bits of each 6-bit group pick the row, inner four the column.
    function automatic half_t sbox_sub(input subkey_t x);
        half_t      r;
        logic [5:0] six;
        for (int i = 0; i < 8; i++)
        begin
            six = x[47-6*i -: 6];
            r[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        return r;
    endfunction

    // Total left rotation of the key halves after round rnd (0-based).
    function automatic int rot_total(input int rnd);
        int s;
        s = 0;
        for (int i = 0; i < ROUNDS; i++)
        begin
            if (i <= rnd)
            begin
                s += ROT_TAB[i];
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

>>> src/desbe_round.sv
`default_nettype none

// One Feistel round: swap halves, mix the right half into the left.
module desbe_round (
    input  wire desbe_pkg::half_t   l_in,
    input  wire desbe_pkg::half_t   r_in,
    input  wire desbe_pkg::subkey_t subkey,
    output desbe_pkg::half_t        l_out,
    output desbe_pkg::half_t        r_out
);

    desbe_pkg::subkey_t mixed;
    desbe_pkg::half_t   f_val;

    always_comb
    begin
        mixed = desbe_pkg::expand_e(r_in) ^ subkey;
        f_val = desbe_pkg::perm_p(desbe_pkg::sbox_sub(mixed));
    end

    assign l_out = r_in;
    assign r_out = l_in ^ f_val;

endmodule

`default_nettype wire

>>> src/des_block_encrypt_unit.sv
// DES ECB encryption, one 64-bit block per transaction.
// done and the cipher block come from the result registers, fed by the input-stage registers that take start.
// Throughput: one block per clock; busy stays low, the 16 rounds sit in one register stage.
// Results cannot be stalled; done is a single-cycle strobe that the receiver must catch.
// Reset (rst_n low, asynchronous) clears the key to zero and drops any transaction in flight.
`default_nettype none

`include "des_block_encrypt_unit_defines.svh"

module des_block_encrypt_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [63:0] plain_block,
    input  wire         des_key_we,
    input  wire  [63:0] des_key,
    output logic        done,
    output logic [63:0] cipher_block
);

    // Key register; the user must write it only while no transaction is in flight; the block does not enforce this.
    logic [63:0] des_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            des_key_reg <= '0;
        end
        else if (des_key_we)
        begin
            des_key_reg <= des_key;
        end
    end

    // Key schedule: pure wiring from the key register. PC-1 splits the key into
    // C and D; each round key is PC-2 of both halves rotated by the running total.
    // Every round rotates by at least one, so the doubled halves drop their top bit.
    logic [desbe_pkg::CD_W-1:0]      key_cd;
    logic [2*desbe_pkg::HALF_CD-2:0] c_dbl;
    logic [2*desbe_pkg::HALF_CD-2:0] d_dbl;
    desbe_pkg::subkey_t              subkey [desbe_pkg::ROUNDS];

    assign key_cd = desbe_pkg::perm_pc1(des_key_reg);
    assign c_dbl  = {key_cd[54:28], key_cd[55:28]};
    assign d_dbl  = {key_cd[26:0],  key_cd[27:0]};

    // The block never stalls: accept a new transaction every clock.
    assign busy = 1'b0;

    // Input stage: hold the block after the initial permutation.
    logic              in_valid_reg;
    desbe_pkg::block_t in_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_block_reg <= desbe_pkg::perm_ip(plain_block);
        end
    end

    // Sixteen rounds chained between the input and result registers.
    desbe_pkg::half_t l_chain [desbe_pkg::ROUNDS+1];
    desbe_pkg::half_t r_chain [desbe_pkg::ROUNDS+1];

    assign l_chain[0] = in_block_reg[63:32];
    assign r_chain[0] = in_block_reg[31:0];

    genvar g;
    generate
        for (g = 0; g < desbe_pkg::ROUNDS; g++)
        begin : g_round
            localparam int SH = desbe_pkg::rot_total(g);

            assign subkey[g] = desbe_pkg::perm_pc2({c_dbl[55-SH -: 28], d_dbl[55-SH -: 28]});

            desbe_round u_round (
                .l_in   (l_chain[g]),
                .r_in   (r_chain[g]),
                .subkey (subkey[g]),
                .l_out  (l_chain[g+1]),
                .r_out  (r_chain[g+1])
            );
        end
    endgenerate

    // Result stage: swap the halves, apply the final permutation, strobe done.
    logic              done_reg;
    desbe_pkg::block_t cipher_reg;
    desbe_pkg::block_t cipher_next;

    assign cipher_next = desbe_pkg::perm_fp({r_chain[desbe_pkg::ROUNDS],
                                             l_chain[desbe_pkg::ROUNDS]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            cipher_reg <= cipher_next;
        end
    end

    assign done         = done_reg;
    assign cipher_block = cipher_reg;

    // Every accepted transaction reaches the result stage exactly once.
    `DESBE_ASSERT_NEXT(a_start_to_stage, start, in_valid_reg)
    `DESBE_ASSERT_NEXT(a_stage_to_done, in_valid_reg, done_reg)
    `DESBE_ASSERT_NEXT(a_no_spurious_done, !in_valid_reg, !done_reg)
    // Hold the result value when no transaction leaves the round logic.
    `DESBE_ASSERT_NEXT(a_result_hold, !in_valid_reg, $stable(cipher_reg))
    `DESBE_ASSERT_NOW(a_never_busy, start, !busy)

endmodule

`default_nettype wire
